### hdl/ddwsl_pkg.sv
// shared types and constants of the differential drive wheel speed limiter
// no dependencies
`timescale 1ns / 1ps

package ddwsl_pkg;

    // field widths of the command and result words
    localparam int VEL_W     = 16;
    localparam int SPEED_W   = 32;

    // configuration register widths
    localparam int RADIUS_W  = 20;
    localparam int SEP_W     = 22;
    localparam int GEAR_W    = 32;
    localparam int MAXSPD_W  = 31;

    // 2*pi as unsigned Q40, rounded to nearest
    localparam int          TWO_PI_W   = 43;
    localparam logic [42:0] TWO_PI_Q40 = 43'h6487ED5110B;

    // mm/s to nm/s, doubled
    localparam int          VSCALE_W = 21;
    localparam logic [20:0] VSCALE   = 21'd2000000;

    // shift that takes the Q16 gear ratio to Q40, the scale of TWO_PI_Q40, after the times-30 factor
    localparam int FRAC_SH = 24;

    // datapath widths
    localparam int TURN_W = VEL_W + SEP_W + 1;
    localparam int VT_W   = VEL_W + VSCALE_W + 1;
    localparam int X2_W   = ((TURN_W > VT_W) ? TURN_W : VT_W) + 1;
    localparam int MAG_W  = X2_W;
    localparam int LIM_W  = (MAXSPD_W < SPEED_W - 1) ? MAXSPD_W : SPEED_W - 1;
    localparam int K_W    = GEAR_W + 5;
    localparam int DEN_W  = TWO_PI_W + RADIUS_W;
    localparam int LD_W   = LIM_W + DEN_W;
    localparam int NK_W   = MAG_W + K_W;
    localparam int NUM_W  = NK_W + FRAC_SH;
    localparam int NL_W   = MAG_W + LIM_W;
    localparam int CMP_W  = (NUM_W > LD_W) ? NUM_W : LD_W;
    localparam int DIV_NW = (NUM_W > NL_W) ? NUM_W : NL_W;
    localparam int DIV_DW = (DEN_W > MAG_W) ? DEN_W : MAG_W;
    localparam int QUO_W  = LIM_W;

    localparam logic [63:0] SPEED_POS_MAX = (64'd1 << (SPEED_W - 1)) - 64'd1;

    // configuration port
    localparam int PADDR_W = 5;
    localparam int RIDX_W  = 3;
    localparam logic [RIDX_W-1:0] REG_RADIUS = 3'd0;
    localparam logic [RIDX_W-1:0] REG_SEP    = 3'd1;
    localparam logic [RIDX_W-1:0] REG_GEAR   = 3'd2;
    localparam logic [RIDX_W-1:0] REG_MAXSPD = 3'd3;
    localparam logic [RIDX_W-1:0] REG_INV_L  = 3'd4;
    localparam logic [RIDX_W-1:0] REG_INV_R  = 3'd5;

    typedef struct packed {
        logic signed [VEL_W-1:0] linear_velocity;
        logic signed [VEL_W-1:0] angular_velocity;
    } cmd_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left_motor_speed;
        logic signed [SPEED_W-1:0] right_motor_speed;
    } rsp_t;

endpackage

### hdl/ddwsl_mul.sv
// two-stage unsigned multiplier, operand a split into two partial products
// no dependencies
`timescale 1ns / 1ps

module ddwsl_mul #(
    parameter int AW = 40,
    parameter int BW = 37
) (
    input  logic          clk,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    output logic [AW+BW-1:0] p
);

    localparam int LW = (AW + 1) / 2;
    localparam int HW = AW - LW;

    logic [LW+BW-1:0] lo_reg;
    logic [HW+BW-1:0] hi_reg;
    logic [AW+BW-1:0] p_reg;

    // partial products, then the shifted sum
    always_ff @(posedge clk)
    begin
        lo_reg <= (LW+BW)'(a[LW-1:0]) * (LW+BW)'(b);
        hi_reg <= (HW+BW)'(a[AW-1:LW]) * (HW+BW)'(b);
        p_reg  <= (AW+BW)'(lo_reg) + ((AW+BW)'(hi_reg) << LW);
    end

    assign p = p_reg;

endmodule

### hdl/ddwsl_div.sv
// pipelined restoring divider, one quotient bit per stage
// no dependencies; the quotient must fit in QW bits
`timescale 1ns / 1ps

module ddwsl_div #(
    parameter int NW = 101,
    parameter int DW = 63,
    parameter int QW = 31,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vld_in,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag_in,
    output logic          vld_out,
    output logic [QW-1:0] quo,
    output logic [TW-1:0] tag_out
);

    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] low_reg [0:QW];
    logic [DW-1:0] d_reg   [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic [TW-1:0] tag_reg [0:QW];
    logic          vld_reg [0:QW];

    // entry: upper part of the dividend is already below the divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= DW'(num >> QW);
        low_reg[0] <= num[QW-1:0];
        d_reg[0]   <= den;
        q_reg[0]   <= '0;
        tag_reg[0] <= tag_in;
    end

    // one trial subtraction per stage
    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        assign trial = {rem_reg[j], low_reg[j][QW-1]};
        assign diff  = trial - {1'b0, d_reg[j]};
        assign ge    = (trial >= {1'b0, d_reg[j]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_reg[j+1] <= low_reg[j] << 1;
            d_reg[j+1]   <= d_reg[j];
            q_reg[j+1]   <= {q_reg[j][QW-2:0], ge};
            tag_reg[j+1] <= tag_reg[j];
        end
    end

    assign vld_out = vld_reg[QW];
    assign quo     = q_reg[QW];
    assign tag_out = tag_reg[QW];

endmodule

### hdl/diff_drive_wheel_speed_limiter_core.sv
// differential drive inverse kinematics with speed limiting, top level
// depends on ddwsl_pkg, ddwsl_mul and ddwsl_div
`timescale 1ns / 1ps

// Takes one command word per clock and returns one result word per command,
// in order. busy is always low and results cannot be held off: each is shown
// for a single cycle with done high. Most of the pipeline is the 31-stage
// restoring divider (one quotient bit per stage), behind five stages of wheel
// speed forming, magnitude and two-stage multipliers. Values derived from the
// registers are registered behind them and settle after a write; commands
// taken after that see the new setting.
module diff_drive_wheel_speed_limiter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ddwsl_pkg::cmd_t                     cmd,
    output logic                                done,
    output ddwsl_pkg::rsp_t                     rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ddwsl_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int LATENCY = ddwsl_pkg::QUO_W + 7;

    // configuration registers
    logic [ddwsl_pkg::RADIUS_W-1:0] radius_reg;
    logic [ddwsl_pkg::SEP_W-1:0]    sep_reg;
    logic [ddwsl_pkg::GEAR_W-1:0]   gear_reg;
    logic [ddwsl_pkg::MAXSPD_W-1:0] maxspd_reg;
    logic                           inv_l_reg;
    logic                           inv_r_reg;
    logic                           cfg_wr;
    logic [ddwsl_pkg::RIDX_W-1:0]   ridx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel & penable & pwrite;
    assign ridx   = paddr[ddwsl_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= ddwsl_pkg::RADIUS_W'(50000);
            sep_reg    <= ddwsl_pkg::SEP_W'(300000);
            gear_reg   <= ddwsl_pkg::GEAR_W'(65536);
            maxspd_reg <= ddwsl_pkg::MAXSPD_W'(3000000);
            inv_l_reg  <= 1'b0;
            inv_r_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (ridx)
                ddwsl_pkg::REG_RADIUS: radius_reg <= pwdata[ddwsl_pkg::RADIUS_W-1:0];
                ddwsl_pkg::REG_SEP:    sep_reg    <= pwdata[ddwsl_pkg::SEP_W-1:0];
                ddwsl_pkg::REG_GEAR:   gear_reg   <= pwdata[ddwsl_pkg::GEAR_W-1:0];
                ddwsl_pkg::REG_MAXSPD: maxspd_reg <= pwdata[ddwsl_pkg::MAXSPD_W-1:0];
                ddwsl_pkg::REG_INV_L:  inv_l_reg  <= pwdata[0];
                ddwsl_pkg::REG_INV_R:  inv_r_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (ridx)
            ddwsl_pkg::REG_RADIUS: prdata = 32'(radius_reg);
            ddwsl_pkg::REG_SEP:    prdata = 32'(sep_reg);
            ddwsl_pkg::REG_GEAR:   prdata = 32'(gear_reg);
            ddwsl_pkg::REG_MAXSPD: prdata = 32'(maxspd_reg);
            ddwsl_pkg::REG_INV_L:  prdata = 32'(inv_l_reg);
            ddwsl_pkg::REG_INV_R:  prdata = 32'(inv_r_reg);
            default:               prdata = '0;
        endcase
    end

    // values derived from the registers
    logic [ddwsl_pkg::K_W-1:0]   k_reg;
    logic [ddwsl_pkg::DEN_W-1:0] den_reg;
    logic [ddwsl_pkg::LIM_W-1:0] lim_reg;
    logic [ddwsl_pkg::LD_W-1:0]  limden;

    always_ff @(posedge clk)
    begin
        k_reg   <= (ddwsl_pkg::K_W'(gear_reg) << 5) - (ddwsl_pkg::K_W'(gear_reg) << 1);
        den_reg <= ddwsl_pkg::DEN_W'(ddwsl_pkg::TWO_PI_Q40)
                 * ddwsl_pkg::DEN_W'(radius_reg);
        lim_reg <= (64'(maxspd_reg) > ddwsl_pkg::SPEED_POS_MAX)
                 ? ddwsl_pkg::SPEED_POS_MAX[ddwsl_pkg::LIM_W-1:0]
                 : maxspd_reg[ddwsl_pkg::LIM_W-1:0];
    end

    ddwsl_mul #(.AW(ddwsl_pkg::DEN_W), .BW(ddwsl_pkg::LIM_W)) u_mul_limden (
        .clk (clk),
        .a   (den_reg),
        .b   (lim_reg),
        .p   (limden)
    );

    // stage 1: turn term and scaled linear speed
    logic                                accept;
    logic signed [ddwsl_pkg::TURN_W-1:0] w_ext;
    logic signed [ddwsl_pkg::TURN_W-1:0] s_ext;
    logic signed [ddwsl_pkg::VT_W-1:0]   v_ext;
    logic signed [ddwsl_pkg::VT_W-1:0]   vs_ext;
    logic signed [ddwsl_pkg::TURN_W-1:0] turn_reg;
    logic signed [ddwsl_pkg::VT_W-1:0]   vt_reg;
    logic                                s1_vld_reg;

    assign accept = start & ~busy;
    assign w_ext  = {{(ddwsl_pkg::TURN_W-ddwsl_pkg::VEL_W){cmd.angular_velocity[ddwsl_pkg::VEL_W-1]}},
                     cmd.angular_velocity};
    assign s_ext  = ddwsl_pkg::TURN_W'(sep_reg);
    assign v_ext  = {{(ddwsl_pkg::VT_W-ddwsl_pkg::VEL_W){cmd.linear_velocity[ddwsl_pkg::VEL_W-1]}},
                     cmd.linear_velocity};
    assign vs_ext = ddwsl_pkg::VT_W'(ddwsl_pkg::VSCALE);

    always_ff @(posedge clk)
    begin
        turn_reg <= w_ext * s_ext;
        vt_reg   <= v_ext * vs_ext;
    end

    // stage 2: doubled wheel speeds
    logic signed [ddwsl_pkg::X2_W-1:0] turn_x;
    logic signed [ddwsl_pkg::X2_W-1:0] vt_x;
    logic signed [ddwsl_pkg::X2_W-1:0] l2_reg;
    logic signed [ddwsl_pkg::X2_W-1:0] r2_reg;
    logic                              s2_vld_reg;

    assign turn_x = {{(ddwsl_pkg::X2_W-ddwsl_pkg::TURN_W){turn_reg[ddwsl_pkg::TURN_W-1]}}, turn_reg};
    assign vt_x   = {{(ddwsl_pkg::X2_W-ddwsl_pkg::VT_W){vt_reg[ddwsl_pkg::VT_W-1]}}, vt_reg};

    always_ff @(posedge clk)
    begin
        l2_reg <= vt_x - turn_x;
        r2_reg <= vt_x + turn_x;
    end

    // stage 3: magnitudes and the larger side
    logic [ddwsl_pkg::MAG_W-1:0] al_next;
    logic [ddwsl_pkg::MAG_W-1:0] ar_next;
    logic [ddwsl_pkg::MAG_W-1:0] al_reg;
    logic [ddwsl_pkg::MAG_W-1:0] ar_reg;
    logic [ddwsl_pkg::MAG_W-1:0] amax3_reg;
    logic                        sl3_reg;
    logic                        sr3_reg;
    logic                        lbig3_reg;
    logic                        s3_vld_reg;

    assign al_next = l2_reg[ddwsl_pkg::X2_W-1] ? ddwsl_pkg::MAG_W'(-l2_reg)
                                               : ddwsl_pkg::MAG_W'(l2_reg);
    assign ar_next = r2_reg[ddwsl_pkg::X2_W-1] ? ddwsl_pkg::MAG_W'(-r2_reg)
                                               : ddwsl_pkg::MAG_W'(r2_reg);

    always_ff @(posedge clk)
    begin
        al_reg    <= al_next;
        ar_reg    <= ar_next;
        amax3_reg <= (al_next >= ar_next) ? al_next : ar_next;
        lbig3_reg <= (al_next >= ar_next);
        sl3_reg   <= l2_reg[ddwsl_pkg::X2_W-1];
        sr3_reg   <= r2_reg[ddwsl_pkg::X2_W-1];
    end

    // stages 4 and 5: products for both the plain and the limited result
    logic [ddwsl_pkg::NK_W-1:0] alk;
    logic [ddwsl_pkg::NK_W-1:0] ark;
    logic [ddwsl_pkg::NL_W-1:0] all;
    logic [ddwsl_pkg::NL_W-1:0] arl;

    ddwsl_mul #(.AW(ddwsl_pkg::MAG_W), .BW(ddwsl_pkg::K_W)) u_mul_lk (
        .clk (clk), .a (al_reg), .b (k_reg), .p (alk)
    );
    ddwsl_mul #(.AW(ddwsl_pkg::MAG_W), .BW(ddwsl_pkg::K_W)) u_mul_rk (
        .clk (clk), .a (ar_reg), .b (k_reg), .p (ark)
    );
    ddwsl_mul #(.AW(ddwsl_pkg::MAG_W), .BW(ddwsl_pkg::LIM_W)) u_mul_llim (
        .clk (clk), .a (al_reg), .b (lim_reg), .p (all)
    );
    ddwsl_mul #(.AW(ddwsl_pkg::MAG_W), .BW(ddwsl_pkg::LIM_W)) u_mul_rlim (
        .clk (clk), .a (ar_reg), .b (lim_reg), .p (arl)
    );

    logic [ddwsl_pkg::MAG_W-1:0] amax4_reg;
    logic [ddwsl_pkg::MAG_W-1:0] amax5_reg;
    logic                        sl4_reg;
    logic                        sr4_reg;
    logic                        lbig4_reg;
    logic                        sl5_reg;
    logic                        sr5_reg;
    logic                        lbig5_reg;
    logic                        s4_vld_reg;
    logic                        s5_vld_reg;

    always_ff @(posedge clk)
    begin
        amax4_reg <= amax3_reg;
        sl4_reg   <= sl3_reg;
        sr4_reg   <= sr3_reg;
        lbig4_reg <= lbig3_reg;
        amax5_reg <= amax4_reg;
        sl5_reg   <= sl4_reg;
        sr5_reg   <= sr4_reg;
        lbig5_reg <= lbig4_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    // limit test and choice of dividend and divisor
    logic [ddwsl_pkg::NK_W-1:0]   nmax;
    logic                         limited;
    logic [ddwsl_pkg::DIV_NW-1:0] num_l;
    logic [ddwsl_pkg::DIV_NW-1:0] num_r;
    logic [ddwsl_pkg::DIV_DW-1:0] dvs;

    assign nmax    = lbig5_reg ? alk : ark;
    assign limited = ({ddwsl_pkg::CMP_W'(nmax)} << ddwsl_pkg::FRAC_SH)
                     > ddwsl_pkg::CMP_W'(limden);

    always_comb
    begin
        if (limited)
        begin
            num_l = ddwsl_pkg::DIV_NW'(all);
            num_r = ddwsl_pkg::DIV_NW'(arl);
            dvs   = ddwsl_pkg::DIV_DW'(amax5_reg);
        end
        else
        begin
            num_l = ddwsl_pkg::DIV_NW'(alk) << ddwsl_pkg::FRAC_SH;
            num_r = ddwsl_pkg::DIV_NW'(ark) << ddwsl_pkg::FRAC_SH;
            // zero radius with zero speed or zero gear: dividend is zero, keep the divisor nonzero
            dvs   = (den_reg == '0) ? ddwsl_pkg::DIV_DW'(1) : ddwsl_pkg::DIV_DW'(den_reg);
        end
    end

    // dividers, sign travels as tag
    logic                        vl;
    logic                        vr;
    logic [ddwsl_pkg::QUO_W-1:0] ql;
    logic [ddwsl_pkg::QUO_W-1:0] qr;
    logic                        sgn_l;
    logic                        sgn_r;

    ddwsl_div #(
        .NW (ddwsl_pkg::DIV_NW), .DW (ddwsl_pkg::DIV_DW), .QW (ddwsl_pkg::QUO_W), .TW (1)
    ) u_div_l (
        .clk (clk), .rst_n (rst_n), .vld_in (s5_vld_reg), .num (num_l), .den (dvs),
        .tag_in (sl5_reg), .vld_out (vl), .quo (ql), .tag_out (sgn_l)
    );

    ddwsl_div #(
        .NW (ddwsl_pkg::DIV_NW), .DW (ddwsl_pkg::DIV_DW), .QW (ddwsl_pkg::QUO_W), .TW (1)
    ) u_div_r (
        .clk (clk), .rst_n (rst_n), .vld_in (s5_vld_reg), .num (num_r), .den (dvs),
        .tag_in (sr5_reg), .vld_out (vr), .quo (qr), .tag_out (sgn_r)
    );

    // output word: sign, optional inversion
    logic signed [ddwsl_pkg::SPEED_W-1:0] ml;
    logic signed [ddwsl_pkg::SPEED_W-1:0] mr;
    logic                                 done_reg;
    ddwsl_pkg::rsp_t                      rsp_reg;

    assign ml = ddwsl_pkg::SPEED_W'(ql);
    assign mr = ddwsl_pkg::SPEED_W'(qr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vl & vr;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg.left_motor_speed  <= (sgn_l ^ inv_l_reg) ? -ml : ml;
        rsp_reg.right_motor_speed <= (sgn_r ^ inv_r_reg) ? -mr : mr;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // checks
    logic signed [ddwsl_pkg::SPEED_W:0] lim_s;

    assign lim_s = (ddwsl_pkg::SPEED_W+1)'(lim_reg);

    assert property (@(posedge clk) disable iff (!rst_n) vl == vr)
        else $error("divider lanes out of step");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(start, LATENCY))
        else $error("result word without a command");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(rsp.left_motor_speed) <= lim_s)
              && ($signed(rsp.left_motor_speed) >= -lim_s)
              && ($signed(rsp.right_motor_speed) <= lim_s)
              && ($signed(rsp.right_motor_speed) >= -lim_s))
        else $error("motor speed beyond limit");

endmodule

### test/diff_drive_wheel_speed_limiter_core_tb.sv
// testbench of the differential drive wheel speed limiter core
// depends on ddwsl_pkg and diff_drive_wheel_speed_limiter_core
`timescale 1ns / 1ps

module diff_drive_wheel_speed_limiter_core_tb;

    localparam int SETTINGS_N = 11;
    localparam int ITEMS_PER_SETTING = 80;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    ddwsl_pkg::cmd_t cmd;
    logic        done;
    ddwsl_pkg::rsp_t rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ddwsl_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // local copy of the register settings
    logic [ddwsl_pkg::RADIUS_W-1:0] radius_um;
    logic [ddwsl_pkg::SEP_W-1:0]    sep_um;
    logic [ddwsl_pkg::GEAR_W-1:0]   gear_q16;
    logic [ddwsl_pkg::MAXSPD_W-1:0] max_mrpm;
    logic                           inv_left;
    logic                           inv_right;

    // expected motor speed words, oldest first
    ddwsl_pkg::rsp_t motor_speeds_q[$];
    int   error_count;

    // typed-in expectation for the word being offered
    logic cur_typed;
    ddwsl_pkg::rsp_t cur_typed_rsp;

    typedef struct {
        int   lin;
        int   ang;
        bit   typed;
        int   left;
        int   right;
    } drive_row_t;

    drive_row_t drive_rows[$];

    diff_drive_wheel_speed_limiter_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // wheel speeds from a body command, limited and inverted
    function automatic ddwsl_pkg::rsp_t predict_wheel_speeds(ddwsl_pkg::cmd_t c);
        longint v;
        longint w;
        longint turn;
        longint l2;
        longint r2;
        longint sl;
        longint sr;
        logic [127:0] al;
        logic [127:0] ar;
        logic [127:0] amax;
        logic [127:0] k;
        logic [127:0] den;
        logic [127:0] lim;
        logic [127:0] num;
        logic [127:0] thr;
        logic [127:0] ml;
        logic [127:0] mr;
        ddwsl_pkg::rsp_t o;
        v = longint'($signed(c.linear_velocity));
        w = longint'($signed(c.angular_velocity));
        turn = w * longint'({1'b0, sep_um});
        l2 = 64'sd2000000 * v - turn;
        r2 = 64'sd2000000 * v + turn;
        al = (l2 < 0) ? 128'(-l2) : 128'(l2);
        ar = (r2 < 0) ? 128'(-r2) : 128'(r2);
        amax = (al > ar) ? al : ar;
        k = 128'(gear_q16) * 128'd30;
        den = 128'(ddwsl_pkg::TWO_PI_Q40) * 128'(radius_um);
        lim = 128'(max_mrpm);
        if (lim > 128'(ddwsl_pkg::SPEED_POS_MAX))
            lim = 128'(ddwsl_pkg::SPEED_POS_MAX);
        num = (amax * k) << ddwsl_pkg::FRAC_SH;
        thr = lim * den;
        if (num > thr)
        begin
            ml = (al * lim) / amax;
            mr = (ar * lim) / amax;
        end
        else if (den != 0)
        begin
            ml = ((al * k) << ddwsl_pkg::FRAC_SH) / den;
            mr = ((ar * k) << ddwsl_pkg::FRAC_SH) / den;
        end
        else
        begin
            ml = '0;
            mr = '0;
        end
        sl = longint'(ml[63:0]);
        sr = longint'(mr[63:0]);
        if (l2 < 0)
            sl = -sl;
        if (r2 < 0)
            sr = -sr;
        if (inv_left)
            sl = -sl;
        if (inv_right)
            sr = -sr;
        o.left_motor_speed  = sl[ddwsl_pkg::SPEED_W-1:0];
        o.right_motor_speed = sr[ddwsl_pkg::SPEED_W-1:0];
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // record the expectation of each accepted command word
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            if (cur_typed)
                motor_speeds_q.push_back(cur_typed_rsp);
            else
                motor_speeds_q.push_back(predict_wheel_speeds(cmd));
        end
    end

    // check each result word against the oldest expectation
    always @(posedge clk)
    begin
        ddwsl_pkg::rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (motor_speeds_q.size() == 0)
                report_mismatch("result word with none expected");
            else
            begin
                exp_rsp = motor_speeds_q.pop_front();
                if (rsp.left_motor_speed !== exp_rsp.left_motor_speed)
                    report_mismatch($sformatf("left %0d expected %0d",
                        rsp.left_motor_speed, exp_rsp.left_motor_speed));
                if (rsp.right_motor_speed !== exp_rsp.right_motor_speed)
                    report_mismatch($sformatf("right %0d expected %0d",
                        rsp.right_motor_speed, exp_rsp.right_motor_speed));
            end
        end
    end

    // two-phase register write
    task automatic write_reg(input logic [ddwsl_pkg::RIDX_W-1:0] idx,
                             input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ddwsl_pkg::REG_RADIUS: radius_um = value[ddwsl_pkg::RADIUS_W-1:0];
            ddwsl_pkg::REG_SEP:    sep_um    = value[ddwsl_pkg::SEP_W-1:0];
            ddwsl_pkg::REG_GEAR:   gear_q16  = value[ddwsl_pkg::GEAR_W-1:0];
            ddwsl_pkg::REG_MAXSPD: max_mrpm  = value[ddwsl_pkg::MAXSPD_W-1:0];
            ddwsl_pkg::REG_INV_L:  inv_left  = value[0];
            ddwsl_pkg::REG_INV_R:  inv_right = value[0];
            default: ;
        endcase
    endtask

    task automatic set_all_regs(input logic [31:0] r, input logic [31:0] s,
                                input logic [31:0] g, input logic [31:0] m,
                                input logic [31:0] il, input logic [31:0] ir);
        // let the pipeline drain before touching the registers
        while (motor_speeds_q.size() != 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
        write_reg(ddwsl_pkg::REG_RADIUS, r);
        write_reg(ddwsl_pkg::REG_SEP, s);
        write_reg(ddwsl_pkg::REG_GEAR, g);
        write_reg(ddwsl_pkg::REG_MAXSPD, m);
        write_reg(ddwsl_pkg::REG_INV_L, il);
        write_reg(ddwsl_pkg::REG_INV_R, ir);
        // let the derived values settle after the write
        repeat (5) @(posedge clk);
    endtask

    // offer one command word and hold it until taken
    task automatic send_word(input int lin, input int ang, input bit typed,
                             input int left, input int right);
        int gap;
        gap = $urandom_range(0, 99);
        if (gap < 55)
            gap = 0;
        else if (gap < 93)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(5, 40);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd.linear_velocity  <= lin[ddwsl_pkg::VEL_W-1:0];
        cmd.angular_velocity <= ang[ddwsl_pkg::VEL_W-1:0];
        cur_typed <= typed;
        cur_typed_rsp.left_motor_speed  <= left;
        cur_typed_rsp.right_motor_speed <= right;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic int rand_vel();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return int'($signed(16'($urandom())));
        else if (sel < 8)
            return $urandom_range(0, 400) - 200;
        else if (sel == 8)
            return $urandom_range(0, 1) ? 32767 : -32768;
        else
            return 0;
    endfunction

    // register settings per phase: radius, separation, gear, limit, inversions
    logic [31:0] phase_regs [SETTINGS_N][6] = '{
        '{32'd50000,   32'd300000,  32'd65536,      32'd3000000,    32'd0, 32'd0},
        '{32'd1,       32'd1,       32'd1,          32'd1,          32'd1, 32'd0},
        '{32'd1000000, 32'd4000000, 32'hFFFFFFFF,   32'h7FFFFFFF,   32'd0, 32'd1},
        '{32'd0,       32'd300000,  32'd65536,      32'd3000000,    32'd1, 32'd1},
        '{32'd50000,   32'd300000,  32'd0,          32'd3000000,    32'd0, 32'd0},
        '{32'd50000,   32'd300000,  32'd65536,      32'd0,          32'd1, 32'd0},
        '{32'd1000000, 32'd1,       32'd65536,      32'h7FFFFFFF,   32'd0, 32'd0},
        '{32'd30000,   32'd4000000, 32'd1310720,    32'd20000000,   32'd1, 32'd1},
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'd6553600, 32'hFFFFFFFF,   32'd3, 32'd2},
        '{32'd1,       32'd4000000, 32'hFFFFFFFF,   32'd1000,       32'd0, 32'd1},
        '{32'd80000,   32'd450000,  32'd983040,     32'd5000000,    32'd0, 32'd0}
    };

    // directed rows at the reset setting
    initial
    begin
        drive_rows = '{
            '{0, 0, 1'b1, 0, 0},
            '{32767, 0, 1'b1, 3000000, 3000000},
            '{-32768, 0, 1'b1, -3000000, -3000000},
            '{0, 32767, 1'b0, 0, 0},
            '{0, -32768, 1'b0, 0, 0},
            '{32767, 32767, 1'b0, 0, 0},
            '{-32768, -32768, 1'b0, 0, 0},
            '{32767, -32768, 1'b0, 0, 0},
            '{1, 0, 1'b0, 0, 0},
            '{-1, 0, 1'b0, 0, 0},
            '{0, 1, 1'b0, 0, 0},
            '{0, -1, 1'b0, 0, 0},
            '{1000, 0, 1'b0, 0, 0},
            '{1000, 1000, 1'b0, 0, 0},
            '{-500, 3000, 1'b0, 0, 0},
            '{21845, -21846, 1'b0, 0, 0}
        };
    end

    // limit on the whole run
    initial
    begin
        #4ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_typed = 1'b0;
        cur_typed_rsp = '0;
        error_count = 0;
        radius_um = 20'd50000;
        sep_um = 22'd300000;
        gear_q16 = 32'd65536;
        max_mrpm = 31'd3000000;
        inv_left = 1'b0;
        inv_right = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (drive_rows[i])
            send_word(drive_rows[i].lin, drive_rows[i].ang, drive_rows[i].typed,
                      drive_rows[i].left, drive_rows[i].right);
        start <= 1'b0;

        for (int p = 0; p < SETTINGS_N + 2; p++)
        begin
            if (p < SETTINGS_N)
                set_all_regs(phase_regs[p][0], phase_regs[p][1], phase_regs[p][2],
                             phase_regs[p][3], phase_regs[p][4], phase_regs[p][5]);
            else
                set_all_regs($urandom_range(1, 1000000), $urandom_range(1, 4000000),
                             $urandom(), $urandom_range(1, 32'h7FFFFFFF),
                             $urandom_range(0, 1), $urandom_range(0, 1));
            for (int n = 0; n < ITEMS_PER_SETTING - 10; n++)
                send_word(rand_vel(), rand_vel(), 1'b0, 0, 0);
            start <= 1'b0;
        end

        while (motor_speeds_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0 && motor_speeds_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### diff_drive_wheel_speed_limiter_core.f
hdl/ddwsl_pkg.sv
hdl/ddwsl_mul.sv
hdl/ddwsl_div.sv
hdl/diff_drive_wheel_speed_limiter_core.sv
test/diff_drive_wheel_speed_limiter_core_tb.sv
